[sv/sha256_stream_hasher_assert.svh]
// assertion macros for the stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// implication checked every clock, off during reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[sv/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// types, constants and round functions shared by the SHA-256 hasher
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RUN,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // block-buffer update selects
    typedef enum logic [1:0] {
        BUF_HOLD,
        BUF_BYTE,
        BUF_PAD,
        BUF_LEN
    } buf_op_t;

    // commands from controller to datapath
    typedef struct packed {
        buf_op_t    buf_op;
        logic       clear_tail;
        logic       start;
        logic       round_en;
        logic       fold;
        logic       reinit;
        logic       out_load;
        logic [2:0] out_idx;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [5:0] pos;
        logic       out_busy;
    } stat_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
    endfunction
endpackage
`default_nettype wire

[sv/sha_datapath.sv]
// ----------------------------------------------------------------------------
// sha_datapath
// block buffer, message schedule, round unit, hash words and output register
// ----------------------------------------------------------------------------
`default_nettype none
module sha_datapath
    import sha_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [7:0] byte_in,
    input  wire cmd_t      cmd,
    output stat_t          stat,
    input  wire logic      out_stall,
    output logic           out_valid,
    output out_beat_t      out_data
);
    logic [31:0] blk_reg [16];
    logic [31:0] blk_next [16];
    logic [31:0] hw_reg [8];
    logic [31:0] rv_reg [8];
    logic [63:0] cnt_reg;
    logic [5:0]  rnd_reg;
    logic        ov_reg;
    out_beat_t   od_reg;

    logic [5:0]  pos;
    logic [3:0]  wi;
    logic [1:0]  bi;
    logic [4:0]  sh;
    logic [31:0] keep;
    logic [63:0] bits;
    logic [31:0] w_new;
    logic [31:0] t1, t2, s0, s1, chv, mj;

    assign pos = cnt_reg[5:0];
    assign wi  = pos[5:2];
    assign bi  = pos[1:0];
    assign sh  = 5'(5'd24 - {bi, 3'b000});
    assign keep = (bi == 2'd0) ? 32'd0 : (32'hffffffff << (6'd32 - {1'b0, bi, 3'b000}));
    assign bits = {cnt_reg[60:0], 3'b000};
    assign stat.pos = pos;
    assign stat.out_busy = ov_reg && out_stall;

    // block buffer next value: byte insert, pad, length, schedule shift
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk_next[i] = blk_reg[i];
        end
        w_new = sig1(blk_reg[14]) + blk_reg[9] + sig0(blk_reg[1]) + blk_reg[0];
        if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                blk_next[i] = blk_reg[i + 1];
            end
            blk_next[15] = w_new;
        end
        else
        begin
            case (cmd.buf_op)
                BUF_BYTE:
                begin
                    blk_next[wi] = (blk_reg[wi] & ~(32'hff << sh)) | ({24'd0, byte_in} << sh);
                end
                BUF_PAD:
                begin
                    blk_next[wi] = (blk_reg[wi] & keep) | (32'h80 << sh);
                    for (int i = 0; i < 16; i++)
                    begin
                        if (4'(i) > wi)
                        begin
                            blk_next[i] = 32'd0;
                        end
                    end
                end
                BUF_LEN:
                begin
                    if (cmd.clear_tail)
                    begin
                        for (int i = 0; i < 14; i++)
                        begin
                            blk_next[i] = 32'd0;
                        end
                    end
                    blk_next[14] = bits[63:32];
                    blk_next[15] = bits[31:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // one compression round
    always_comb
    begin
        s1  = rotr(rv_reg[4], 5'd6) ^ rotr(rv_reg[4], 5'd11) ^ rotr(rv_reg[4], 5'd25);
        chv = (rv_reg[4] & rv_reg[5]) ^ (~rv_reg[4] & rv_reg[6]);
        s0  = rotr(rv_reg[0], 5'd2) ^ rotr(rv_reg[0], 5'd13) ^ rotr(rv_reg[0], 5'd22);
        mj  = (rv_reg[0] & rv_reg[1]) ^ (rv_reg[0] & rv_reg[2]) ^ (rv_reg[1] & rv_reg[2]);
        t1  = rv_reg[7] + s1 + chv + ROUND_K[rnd_reg] + blk_reg[0];
        t2  = s0 + mj;
    end

    // block buffer and working variables
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk_reg[i] <= blk_next[i];
        end
        if (cmd.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                rv_reg[i] <= hw_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            rv_reg[7] <= rv_reg[6];
            rv_reg[6] <= rv_reg[5];
            rv_reg[5] <= rv_reg[4];
            rv_reg[4] <= rv_reg[3] + t1;
            rv_reg[3] <= rv_reg[2];
            rv_reg[2] <= rv_reg[1];
            rv_reg[1] <= rv_reg[0];
            rv_reg[0] <= t1 + t2;
        end
    end

    // control state: hash words, count, round index, output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hw_reg[i] <= H_INIT[i];
            end
            cnt_reg <= '0;
            rnd_reg <= '0;
            ov_reg  <= 1'b0;
            od_reg  <= '0;
        end
        else
        begin
            if (cmd.buf_op == BUF_BYTE && !cmd.round_en)
            begin
                cnt_reg <= cnt_reg + 64'd1;
            end
            if (cmd.reinit)
            begin
                cnt_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    hw_reg[i] <= H_INIT[i];
                end
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hw_reg[i] <= hw_reg[i] + rv_reg[i];
                end
            end
            if (cmd.start)
            begin
                rnd_reg <= '0;
            end
            else if (cmd.round_en)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
                od_reg.digest_word <= hw_reg[cmd.out_idx];
                od_reg.word_index  <= cmd.out_idx;
                od_reg.last_word   <= (cmd.out_idx == 3'd7);
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule
`default_nettype wire

[sv/sha_ctrl.sv]
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer: absorb, pad, 64 rounds, fold and digest emission
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_op,
    output logic          in_stall,
    input  wire stat_t    stat,
    output cmd_t          cmd,
    output state_t        state
);
    state_t     state_reg, state_next;
    logic [5:0] rc_reg, rc_next;
    logic       fin_reg, fin_next;   // finish in progress
    logic       ext_reg, ext_next;   // length block still pending
    logic [2:0] oi_reg, oi_next;

    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rc_reg    <= '0;
            fin_reg   <= 1'b0;
            ext_reg   <= 1'b0;
            oi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rc_reg    <= rc_next;
            fin_reg   <= fin_next;
            ext_reg   <= ext_next;
            oi_reg    <= oi_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        rc_next    = rc_reg;
        fin_next   = fin_reg;
        ext_next   = ext_reg;
        oi_next    = oi_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!in_op)
                    begin
                        cmd.buf_op = BUF_BYTE;
                        if (stat.pos == 6'd63)
                        begin
                            fin_next   = 1'b0;
                            state_next = ST_RUN;
                            cmd.start  = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.buf_op = BUF_PAD;
                        fin_next   = 1'b1;
                        ext_next   = (stat.pos > 6'd55);
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // length words go in now unless an extra block is needed first
                if (!ext_reg)
                begin
                    cmd.buf_op = BUF_LEN;
                end
                cmd.start  = 1'b1;
                rc_next    = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.round_en = 1'b1;
                rc_next = rc_reg + 6'd1;
                if (rc_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                rc_next  = '0;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (ext_reg)
                begin
                    ext_next       = 1'b0;
                    cmd.buf_op     = BUF_LEN;
                    cmd.clear_tail = 1'b1;
                    state_next     = ST_PAD;
                end
                else
                begin
                    oi_next    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_idx  = oi_reg;
                    oi_next      = oi_reg + 3'd1;
                    if (oi_reg == 3'd7)
                    begin
                        cmd.reinit = 1'b1;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[sv/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-serial SHA-256 with padding and eight-word digest output
// ----------------------------------------------------------------------------
// A data byte is taken whenever the hasher is idle; the 64th byte of a block
// starts the compression, which runs one round per cycle in a single shared
// round unit and stalls the input through the 64 rounds and the fold. A finish
// beat pads and runs one or two compressions (each with load, 64 rounds and
// fold), then hands out the eight digest words, one beat per cycle while the
// output is not stalled.
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_beat_t      out_data
);
    cmd_t   cmd;
    stat_t  stat;
    state_t state;

    sha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.operation),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    sha_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (in_data.data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`include "sha256_stream_hasher_assert.svh"
    // input is never taken while a compression runs
    `SHA_ASSERT_IMP(a_no_in_busy, state != ST_IDLE, in_stall, "input taken while busy")
    // a stalled output beat keeps its payload
    `SHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "out beat changed")
    // the last digest word returns the block to idle
    `SHA_ASSERT_NEXT(a_last_idle, cmd.out_load && cmd.out_idx == 3'd7, state == ST_IDLE, "no idle")
endmodule
`default_nettype wire
